@@ design/cvsp_pkg.sv @@
// ----------------------------------------------------------------------------
// cvsp_pkg
// Shared types and constants of the cache, victim buffer and stride prefetcher.
// ----------------------------------------------------------------------------
package cvsp_pkg;

  localparam int LineAw      = 10;              // main-cache slots, log2
  localparam int MaxLines    = 1 << LineAw;
  localparam int MaxWaysLog2 = 4;
  localparam int VicAw       = 3;
  localparam int VictimDepth = 1 << VicAw;
  localparam int MaxPrefetch = 8;
  localparam int AddrW       = 64;
  localparam int StampW      = 64;
  localparam logic [StampW-1:0] StampReset = 64'd100;

  typedef struct packed {
    logic [AddrW-1:0]  tag;
    logic [StampW-1:0] stamp;
    logic              valid;
    logic              dirty;
    logic              pf;
  } line_t;

  localparam int LineW = $bits(line_t);

  typedef enum logic [2:0] {
    CfgLineLog2 = 3'd0,
    CfgBlockOff = 3'd1,
    CfgWaysLog2 = 3'd2,
    CfgVictims  = 3'd3,
    CfgDegree   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StScan,
    StWait,
    StUpdate,
    StPfStart,
    StDone
  } state_e;

  typedef struct packed {
    logic              clear;
    logic [LineAw-1:0] clr_addr;
    logic              load;
    logic              scan;
    logic [4:0]        scan_k;
    logic              update;
    logic              pf_mode;
    logic              pf_start;
  } cmd_t;

  typedef struct packed {
    logic       l1_hit;
    logic       stride_match;
    logic [4:0] scan_len;
    logic [3:0] degree;
  } status_t;

  function automatic logic [StampW-1:0] stamp_below(input logic [StampW-1:0] s);
    stamp_below = (s == '0) ? '0 : s - StampW'(1);
  endfunction

endpackage

@@ design/cvsp_ram.sv @@
// ----------------------------------------------------------------------------
// cvsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cvsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/cvsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// cvsp_ctrl
// Sequencer: clearing pass, way/victim scans, updates and prefetch steps.
// ----------------------------------------------------------------------------
module cvsp_ctrl import cvsp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy_o,
  output logic    done_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e            state_q, state_d;
  logic [4:0]        k_q, k_d;
  logic [3:0]        j_q, j_d;
  logic [LineAw-1:0] clr_q, clr_d;
  logic              pf_q, pf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      k_q     <= '0;
      j_q     <= '0;
      clr_q   <= '0;
      pf_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      j_q     <= j_d;
      clr_q   <= clr_d;
      pf_q    <= pf_d;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    j_d     = j_q;
    clr_d   = clr_q;
    pf_d    = pf_q;
    cmd_o   = '0;
    cmd_o.clr_addr = clr_q;
    cmd_o.scan_k   = k_q;
    cmd_o.pf_mode  = pf_q;
    case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        clr_d = clr_q + LineAw'(1);
        if (clr_q == '1) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          pf_d    = 1'b0;
          k_d     = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (k_q == status_i.scan_len - 5'd1) begin
          state_d = StWait;
        end else begin
          k_d = k_q + 5'd1;
        end
      end
      StWait: begin
        state_d = StUpdate;
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        k_d = '0;
        if (!pf_q) begin
          if (status_i.l1_hit || status_i.degree == '0) begin
            state_d = StDone;
          end else begin
            state_d = StPfStart;
          end
        end else if (j_q == status_i.degree) begin
          state_d = StDone;
        end else begin
          j_d     = j_q + 4'd1;
          state_d = StScan;
        end
      end
      StPfStart: begin
        cmd_o.pf_start = 1'b1;
        if (status_i.stride_match) begin
          pf_d    = 1'b1;
          j_d     = 4'd1;
          k_d     = '0;
          state_d = StScan;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StDone);

endmodule

@@ design/cvsp_datapath.sv @@
// ----------------------------------------------------------------------------
// cvsp_datapath
// Configuration, line store, victim buffer, scan accumulators and results.
// ----------------------------------------------------------------------------
module cvsp_datapath import cvsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [4:0]       cfg_data_i,
  input  logic             operation_i,
  input  logic [AddrW-1:0] address_i,
  output logic             l1_hit_o,
  output logic             victim_hit_o,
  output logic             demand_writeback_o,
  output logic             useful_prefetch_o,
  output logic [3:0]       prefetch_count_o,
  output logic [3:0]       prefetch_writebacks_o
);

  // configuration
  logic [3:0] lcl_q, ve_q, pd_q;
  logic [4:0] boff_q;
  logic [2:0] wl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcl_q  <= 4'd9;
      boff_q <= 5'd5;
      wl_q   <= 3'd1;
      ve_q   <= 4'd2;
      pd_q   <= 4'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgLineLog2: lcl_q  <= cfg_data_i[3:0];
        CfgBlockOff: boff_q <= cfg_data_i;
        CfgWaysLog2: wl_q   <= cfg_data_i[2:0];
        CfgVictims:  ve_q   <= cfg_data_i[3:0];
        CfgDegree:   pd_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic [3:0] geo_l, geo_w0, geo_w, geo_idx, victims, degree;
  logic [4:0] ways, scan_len;
  logic [LineAw-1:0] set_mask;

  always_comb begin
    geo_l   = (lcl_q > 4'(LineAw)) ? 4'(LineAw) : lcl_q;
    geo_w0  = ({1'b0, wl_q} > geo_l) ? geo_l : {1'b0, wl_q};
    geo_w   = (geo_w0 > 4'(MaxWaysLog2)) ? 4'(MaxWaysLog2) : geo_w0;
    geo_idx = geo_l - geo_w;
    ways    = 5'd1 << geo_w;
    victims = (ve_q > 4'(VictimDepth)) ? 4'(VictimDepth) : ve_q;
    degree  = (pd_q > 4'(MaxPrefetch)) ? 4'(MaxPrefetch) : pd_q;
    scan_len = (ways > {1'b0, victims}) ? ways : {1'b0, victims};
    set_mask = ~({LineAw{1'b1}} << geo_idx);
  end

  // current lookup
  logic             op_q;
  logic [AddrW-1:0] la_q, stride_q, last_miss_q, prev_stride_q;
  logic [StampW-1:0] ac_q;
  logic [AddrW-1:0] ti, tag, blk, stride_new;
  logic [LineAw-1:0] set;

  always_comb begin
    ti         = la_q >> boff_q;
    set        = ti[LineAw-1:0] & set_mask;
    tag        = la_q >> ({1'b0, boff_q} + {2'b0, geo_idx});
    blk        = la_q & ({AddrW{1'b1}} << boff_q);
    stride_new = blk - last_miss_q;
  end

  // line store
  logic              ram_we;
  logic [LineAw-1:0] ram_waddr, ram_raddr, eaddr;
  line_t             ram_wdata, rd;
  logic [LineW-1:0]  ram_rdata;

  cvsp_ram #(.Width(LineW), .Depth(MaxLines)) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd        = line_t'(ram_rdata);
  assign ram_raddr = set | ({5'b0, cmd_i.scan_k} << geo_idx);

  // victim buffer
  logic [AddrW-1:0]  vblock_q [VictimDepth];
  logic [StampW-1:0] vstamp_q [VictimDepth];
  logic [VictimDepth-1:0] vvalid_q, vdirty_q, vpf_q;

  // scan accumulators
  logic             eval_q;
  logic [4:0]       ek_q;
  logic             hit_f_q, hit_f_d, inv_f_q, inv_f_d;
  logic [LineAw-1:0] hit_a_q, hit_a_d, inv_a_q, inv_a_d, rep_a_q, rep_a_d;
  line_t            hit_l_q, hit_l_d, rep_l_q, rep_l_d;
  logic             vh_f_q, vh_f_d, vinv_f_q, vinv_f_d, vold_f_q, vold_f_d;
  logic [VicAw-1:0] vh_i_q, vh_i_d, vinv_i_q, vinv_i_d, vold_i_q, vold_i_d;
  logic [AddrW-1:0] vh_blk_q, vh_blk_d;
  logic [StampW-1:0] vold_stamp_q, vold_stamp_d;
  logic             vh_dirty_q, vh_dirty_d, vh_pf_q, vh_pf_d, vold_dirty_q, vold_dirty_d;

  logic             first, way_ok, vic_ok;
  logic [VicAw-1:0] ev;

  always_comb begin
    first  = (ek_q == '0);
    way_ok = (ek_q < ways);
    vic_ok = (ek_q < {1'b0, victims});
    ev     = ek_q[VicAw-1:0];
    eaddr  = set | ({5'b0, ek_q} << geo_idx);

    hit_f_d = hit_f_q;  hit_a_d = hit_a_q;  hit_l_d = hit_l_q;
    inv_f_d = inv_f_q;  inv_a_d = inv_a_q;
    rep_a_d = rep_a_q;  rep_l_d = rep_l_q;
    vh_f_d = vh_f_q;  vh_i_d = vh_i_q;  vh_blk_d = vh_blk_q;
    vh_dirty_d = vh_dirty_q;  vh_pf_d = vh_pf_q;
    vinv_f_d = vinv_f_q;  vinv_i_d = vinv_i_q;
    vold_f_d = vold_f_q;  vold_i_d = vold_i_q;  vold_stamp_d = vold_stamp_q;
    vold_dirty_d = vold_dirty_q;

    if (eval_q) begin
      hit_f_d  = hit_f_q & ~first;
      inv_f_d  = inv_f_q & ~first;
      vh_f_d   = vh_f_q & ~first;
      vinv_f_d = vinv_f_q & ~first;
      vold_f_d = vold_f_q & ~first;
      if (way_ok) begin
        if (first) begin
          rep_a_d = eaddr;
          rep_l_d = rd;
        end else if (rd.valid && rd.stamp < rep_l_q.stamp) begin
          rep_a_d = eaddr;
          rep_l_d = rd;
        end
        if (!hit_f_d && rd.valid && rd.tag == tag) begin
          hit_f_d = 1'b1;
          hit_a_d = eaddr;
          hit_l_d = rd;
        end
        if (!inv_f_d && !rd.valid) begin
          inv_f_d = 1'b1;
          inv_a_d = eaddr;
        end
      end
      if (vic_ok) begin
        if (!vh_f_d && vvalid_q[ev] && vblock_q[ev] == ti) begin
          vh_f_d     = 1'b1;
          vh_i_d     = ev;
          vh_blk_d   = vblock_q[ev];
          vh_dirty_d = vdirty_q[ev];
          vh_pf_d    = vpf_q[ev];
        end
        if (!vinv_f_d && !vvalid_q[ev]) begin
          vinv_f_d = 1'b1;
          vinv_i_d = ev;
        end
        if (vvalid_q[ev] && (!vold_f_d || vstamp_q[ev] < vold_stamp_q)) begin
          vold_f_d     = 1'b1;
          vold_i_d     = ev;
          vold_stamp_d = vstamp_q[ev];
          vold_dirty_d = vdirty_q[ev];
        end
      end
    end
  end

  // update decisions
  logic             d_hit, d_vh, d_inv, d_full, pf, has_vic, wb, line_we, vic_we;
  logic [LineAw-1:0] upd_addr;
  line_t            upd_line, clr_line;
  logic [VicAw-1:0] vic_i;
  logic [AddrW-1:0] vic_blk;
  logic [StampW-1:0] below_rep, ac_next;

  always_comb begin
    pf        = cmd_i.pf_mode;
    has_vic   = (victims != '0);
    d_hit     = hit_f_q;
    d_vh      = !d_hit && vh_f_q;
    d_inv     = !d_hit && !d_vh && inv_f_q;
    d_full    = !d_hit && !d_vh && !inv_f_q;
    below_rep = stamp_below(rep_l_q.stamp);
    ac_next   = ac_q + StampW'(1);
    wb        = has_vic ? (!vinv_f_q && vold_f_q && vold_dirty_q)
                        : (rep_l_q.valid && rep_l_q.dirty);

    line_we  = !(d_hit && pf);
    upd_line = '0;
    upd_line.valid = 1'b1;
    upd_addr = rep_a_q;
    if (d_hit) begin
      upd_addr       = hit_a_q;
      upd_line.tag   = hit_l_q.tag;
      upd_line.stamp = ac_q;
      upd_line.dirty = hit_l_q.dirty | op_q;
      upd_line.pf    = 1'b0;
    end else if (d_vh) begin
      upd_line.tag   = vh_blk_q >> geo_idx;
      upd_line.stamp = pf ? below_rep : ac_q;
      upd_line.dirty = vh_dirty_q | (op_q & ~pf);
      upd_line.pf    = pf;
    end else begin
      if (d_inv) begin
        upd_addr = inv_a_q;
      end
      upd_line.tag   = tag;
      upd_line.stamp = pf ? below_rep : ac_q;
      upd_line.dirty = op_q & ~pf;
      upd_line.pf    = pf;
    end

    vic_we  = d_vh || (d_full && has_vic);
    vic_i   = d_vh ? vh_i_q : (vinv_f_q ? vinv_i_q : vold_i_q);
    vic_blk = (rep_l_q.tag << geo_idx) | {{(AddrW-LineAw){1'b0}}, set};

    clr_line       = '0;
    clr_line.stamp = StampReset;

    ram_we    = cmd_i.clear || (cmd_i.update && line_we);
    ram_waddr = cmd_i.clear ? cmd_i.clr_addr : upd_addr;
    ram_wdata = cmd_i.clear ? clr_line : upd_line;
  end

  // results
  logic       l1_hit_q, vhit_q, dwb_q, useful_q;
  logic [3:0] pcount_q, pwb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_q        <= 1'b0;
      ek_q          <= '0;
      ac_q          <= StampReset;
      last_miss_q   <= '0;
      prev_stride_q <= '0;
      vvalid_q      <= '0;
      vdirty_q      <= '0;
      vpf_q         <= '0;
      for (int i = 0; i < VictimDepth; i++) begin
        vblock_q[i] <= '0;
        vstamp_q[i] <= StampReset;
      end
      l1_hit_q <= 1'b0;
      vhit_q   <= 1'b0;
      dwb_q    <= 1'b0;
      useful_q <= 1'b0;
      pcount_q <= '0;
      pwb_q    <= '0;
    end else begin
      eval_q <= cmd_i.scan;
      ek_q   <= cmd_i.scan_k;
      if (cmd_i.load) begin
        ac_q     <= ac_next;
        l1_hit_q <= 1'b0;
        vhit_q   <= 1'b0;
        dwb_q    <= 1'b0;
        useful_q <= 1'b0;
        pcount_q <= '0;
        pwb_q    <= '0;
      end
      if (cmd_i.pf_start) begin
        last_miss_q   <= blk;
        prev_stride_q <= stride_new;
        pcount_q      <= (stride_new == prev_stride_q) ? degree : 4'd0;
      end
      if (cmd_i.update) begin
        if (vic_we) begin
          vblock_q[vic_i] <= vic_blk;
          vvalid_q[vic_i] <= 1'b1;
          vdirty_q[vic_i] <= rep_l_q.dirty;
          vpf_q[vic_i]    <= rep_l_q.pf;
          if (!d_vh) begin
            vstamp_q[vic_i] <= pf ? ac_next : ac_q;
          end
        end
        if (pf) begin
          if (d_full) begin
            pwb_q <= pwb_q + {3'b0, wb};
          end
          if (d_full && has_vic) begin
            ac_q <= ac_next;
          end
        end else begin
          l1_hit_q <= d_hit;
          vhit_q   <= d_vh;
          dwb_q    <= d_full && wb;
          useful_q <= d_hit ? hit_l_q.pf : (d_vh && vh_pf_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= operation_i;
      la_q <= address_i;
    end else if (cmd_i.pf_start) begin
      stride_q <= stride_new;
      la_q     <= blk + stride_new;
    end else if (cmd_i.update && pf) begin
      la_q <= la_q + stride_q;
    end
    hit_f_q <= hit_f_d;  hit_a_q <= hit_a_d;  hit_l_q <= hit_l_d;
    inv_f_q <= inv_f_d;  inv_a_q <= inv_a_d;
    rep_a_q <= rep_a_d;  rep_l_q <= rep_l_d;
    vh_f_q <= vh_f_d;  vh_i_q <= vh_i_d;  vh_blk_q <= vh_blk_d;
    vh_dirty_q <= vh_dirty_d;  vh_pf_q <= vh_pf_d;
    vinv_f_q <= vinv_f_d;  vinv_i_q <= vinv_i_d;
    vold_f_q <= vold_f_d;  vold_i_q <= vold_i_d;  vold_stamp_q <= vold_stamp_d;
    vold_dirty_q <= vold_dirty_d;
  end

  // a victim entry refilled on a victim hit keeps its own stamp
  always_comb begin
    status_o              = '0;
    status_o.l1_hit       = hit_f_q;
    status_o.stride_match = (stride_new == prev_stride_q);
    status_o.scan_len     = scan_len;
    status_o.degree       = degree;
  end

  assign l1_hit_o              = l1_hit_q;
  assign victim_hit_o          = vhit_q;
  assign demand_writeback_o    = dwb_q;
  assign useful_prefetch_o     = useful_q;
  assign prefetch_count_o      = pcount_q;
  assign prefetch_writebacks_o = pwb_q;

endmodule

@@ design/cache_victim_stride_prefetch_top.sv @@
// ----------------------------------------------------------------------------
// cache_victim_stride_prefetch_top
// Set-associative cache with FIFO victim buffer and stride prefetcher.
// ----------------------------------------------------------------------------
// the scan steps over max(ways, victim entries) positions of the set, one way read a
// cycle through the single read port of the line RAM; a hit then updates and is done,
// a miss with a matching stride adds one such scan and update per prefetched block
// one item at a time: busy_o stays high until done_o, results hold until next
// after reset a clearing pass runs through every line RAM slot with busy_o
// high; the result strobe cannot be stalled
module cache_victim_stride_prefetch_top import cvsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             operation_i,
  input  logic [AddrW-1:0] address_i,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [4:0]       cfg_data_i,
  output logic             done_o,
  output logic             l1_hit_o,
  output logic             victim_hit_o,
  output logic             demand_writeback_o,
  output logic             useful_prefetch_o,
  output logic [3:0]       prefetch_count_o,
  output logic [3:0]       prefetch_writebacks_o
);

  cmd_t    cmd;
  status_t status;

  cvsp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .status_i(status),
    .cmd_o   (cmd)
  );

  cvsp_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .operation_i          (operation_i),
    .address_i            (address_i),
    .l1_hit_o             (l1_hit_o),
    .victim_hit_o         (victim_hit_o),
    .demand_writeback_o   (demand_writeback_o),
    .useful_prefetch_o    (useful_prefetch_o),
    .prefetch_count_o     (prefetch_count_o),
    .prefetch_writebacks_o(prefetch_writebacks_o)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cache with victim buffer and stride prefetcher:
// a scoreboard class predicts every access result and checks it in order,
// over directed accesses and random streams under several cache geometries.
// ----------------------------------------------------------------------------

import cvsp_pkg::*;

class cache_scoreboard;

  typedef struct {
    bit       l1_hit;
    bit       victim_hit;
    bit       demand_wb;
    bit       useful_pf;
    bit [3:0] pf_count;
    bit [3:0] pf_wbs;
  } access_result_t;

  bit [63:0] ln_tag[MaxLines];
  bit        ln_valid[MaxLines], ln_dirty[MaxLines], ln_pf[MaxLines];
  bit [63:0] ln_stamp[MaxLines];
  bit [63:0] vc_block[VictimDepth];
  bit        vc_valid[VictimDepth], vc_dirty[VictimDepth], vc_pf[VictimDepth];
  bit [63:0] vc_stamp[VictimDepth];
  bit [63:0] access_clock, last_miss_blk, prev_stride;
  bit [4:0]  regs[5];
  int unsigned idx_bits, n_ways, n_sets, n_vics, degree, boff;
  access_result_t pending[$];
  int errors;

  function new();
    for (int i = 0; i < MaxLines; i++) begin
      ln_tag[i] = 0; ln_valid[i] = 0; ln_dirty[i] = 0; ln_pf[i] = 0;
      ln_stamp[i] = StampReset;
    end
    for (int i = 0; i < VictimDepth; i++) begin
      vc_block[i] = 0; vc_valid[i] = 0; vc_dirty[i] = 0; vc_pf[i] = 0;
      vc_stamp[i] = StampReset;
    end
    access_clock = StampReset;
    last_miss_blk = 0;
    prev_stride = 0;
    regs = '{5'd9, 5'd5, 5'd1, 5'd2, 5'd2};
    errors = 0;
    settle();
  endfunction

  function void settle();
    int unsigned l, w;
    l = regs[CfgLineLog2] & 15;
    w = regs[CfgWaysLog2] & 7;
    while (l > 0 && (1 << l) > MaxLines) l--;
    if (w > l) w = l;
    while (w > 0 && (1 << w) > 16) w--;
    idx_bits = l - w;
    n_ways = 1 << w;
    n_sets = 1 << idx_bits;
    n_vics = regs[CfgVictims] & 15;
    if (n_vics > VictimDepth) n_vics = VictimDepth;
    degree = regs[CfgDegree] & 15;
    if (degree > MaxPrefetch) degree = MaxPrefetch;
    boff = regs[CfgBlockOff] & 31;
  endfunction

  function void write_reg(cfg_idx_e idx, bit [4:0] val);
    case (idx)
      CfgBlockOff: regs[idx] = val;
      CfgWaysLog2: regs[idx] = val & 5'd7;
      default:     regs[idx] = val & 5'd15;
    endcase
    settle();
  endfunction

  function int unsigned lru_slot(int unsigned set);
    int unsigned best;
    bit [63:0] t;
    best = set;
    t = ln_stamp[set];
    for (int unsigned w = 0; w < n_ways; w++) begin
      if (ln_valid[set + w * n_sets] && t > ln_stamp[set + w * n_sets]) begin
        t = ln_stamp[set + w * n_sets];
        best = set + w * n_sets;
      end
    end
    return best;
  endfunction

  function int unsigned oldest_victim();
    int unsigned best;
    bit found;
    bit [63:0] t;
    best = 0; found = 0; t = 0;
    for (int unsigned i = 0; i < n_vics; i++) if (!vc_valid[i]) return i;
    for (int unsigned i = 0; i < n_vics; i++) begin
      if (vc_valid[i] && (!found || t > vc_stamp[i])) begin
        t = vc_stamp[i]; best = i; found = 1;
      end
    end
    return best;
  endfunction

  function int find_line(int unsigned set, bit [63:0] tag);
    for (int unsigned w = 0; w < n_ways; w++)
      if (ln_valid[set + w * n_sets] && ln_tag[set + w * n_sets] == tag)
        return set + w * n_sets;
    return -1;
  endfunction

  function int find_victim(bit [63:0] blk);
    for (int unsigned i = 0; i < n_vics; i++)
      if (vc_valid[i] && vc_block[i] == blk) return i;
    return -1;
  endfunction

  // exchange a victim entry with the set's replacement line
  function int unsigned swap_victim(int unsigned vi, int unsigned set,
                                    output bit [63:0] old_stamp);
    int unsigned l;
    bit [63:0] otag;
    bit od, op;
    l = lru_slot(set);
    otag = ln_tag[l]; od = ln_dirty[l]; op = ln_pf[l];
    old_stamp = ln_stamp[l];
    ln_tag[l] = vc_block[vi] >> idx_bits;
    ln_valid[l] = 1;
    ln_dirty[l] = vc_dirty[vi];
    ln_pf[l] = vc_pf[vi];
    ln_stamp[l] = vc_stamp[vi];
    vc_block[vi] = (otag << idx_bits) | set;
    vc_valid[vi] = 1;
    vc_dirty[vi] = od;
    vc_pf[vi] = op;
    return l;
  endfunction

  function bit evict_to_victim(int unsigned l, int unsigned set);
    int unsigned f;
    bit wb;
    f = oldest_victim();
    wb = vc_valid[f] && vc_dirty[f];
    vc_block[f] = (ln_tag[l] << idx_bits) | set;
    vc_valid[f] = 1;
    vc_dirty[f] = ln_dirty[l];
    vc_pf[f] = ln_pf[l];
    vc_stamp[f] = access_clock;
    return wb;
  endfunction

  function bit [63:0] one_below(bit [63:0] s);
    return (s == 0) ? 64'd0 : s - 64'd1;
  endfunction

  function void run_stride(bit [63:0] addr, inout int unsigned cnt, inout int unsigned wbs);
    bit [63:0] blk, stride, fa, ti, tag, os;
    int unsigned set, l;
    int vi;
    bit placed;
    blk = (addr >> boff) << boff;
    stride = blk - last_miss_blk;
    last_miss_blk = blk;
    if (stride == prev_stride) begin
      for (int unsigned j = 1; j <= degree; j++) begin
        fa = blk + stride * j;
        ti = fa >> boff;
        set = 32'(ti & 64'(n_sets - 1));
        tag = fa >> (boff + idx_bits);
        placed = 0;
        cnt++;
        if (find_line(set, tag) >= 0) continue;
        vi = find_victim(ti);
        if (vi >= 0) begin
          l = swap_victim(vi, set, os);
          ln_stamp[l] = one_below(os);
          ln_pf[l] = 1;
          continue;
        end
        for (int unsigned w = 0; w < n_ways && !placed; w++) begin
          l = set + w * n_sets;
          if (!ln_valid[l]) begin
            os = ln_stamp[lru_slot(set)];
            ln_tag[l] = tag; ln_valid[l] = 1; ln_pf[l] = 1;
            ln_stamp[l] = one_below(os); ln_dirty[l] = 0;
            placed = 1;
          end
        end
        if (placed) continue;
        l = lru_slot(set);
        if (n_vics > 0) begin
          access_clock++;
          wbs += evict_to_victim(l, set);
        end else if (ln_valid[l] && ln_dirty[l]) begin
          wbs++;
        end
        ln_tag[l] = tag;
        ln_stamp[l] = one_below(ln_stamp[l]);
        ln_valid[l] = 1; ln_pf[l] = 1; ln_dirty[l] = 0;
      end
    end
    prev_stride = stride;
  endfunction

  function void note_access(bit wr, bit [63:0] addr);
    access_result_t r;
    bit [63:0] ti, tag, os;
    int unsigned set, l, cnt, wbs;
    int f, vi;
    bit placed;
    r = '{default: 0};
    cnt = 0; wbs = 0;
    ti = addr >> boff;
    set = 32'(ti & 64'(n_sets - 1));
    tag = addr >> (boff + idx_bits);
    access_clock++;
    f = find_line(set, tag);
    if (f >= 0) begin
      r.l1_hit = 1;
      ln_stamp[f] = access_clock;
      if (ln_pf[f]) begin r.useful_pf = 1; ln_pf[f] = 0; end
      if (wr) ln_dirty[f] = 1;
    end else begin
      vi = find_victim(ti);
      if (vi >= 0) begin
        l = swap_victim(vi, set, os);
        r.victim_hit = 1;
        if (ln_pf[l]) begin r.useful_pf = 1; ln_pf[l] = 0; end
        if (wr) ln_dirty[l] = 1;
        ln_stamp[l] = access_clock;
      end else begin
        placed = 0;
        for (int unsigned w = 0; w < n_ways && !placed; w++) begin
          l = set + w * n_sets;
          if (!ln_valid[l]) begin
            ln_tag[l] = tag; ln_valid[l] = 1; ln_stamp[l] = access_clock;
            ln_dirty[l] = wr; ln_pf[l] = 0;
            placed = 1;
          end
        end
        if (!placed) begin
          l = lru_slot(set);
          if (n_vics > 0) r.demand_wb = evict_to_victim(l, set);
          else if (ln_valid[l] && ln_dirty[l]) r.demand_wb = 1;
          ln_tag[l] = tag; ln_valid[l] = 1; ln_pf[l] = 0;
          ln_dirty[l] = wr; ln_stamp[l] = access_clock;
        end
      end
      if (degree > 0) run_stride(addr, cnt, wbs);
    end
    r.pf_count = cnt[3:0];
    r.pf_wbs = wbs[3:0];
    pending.push_back(r);
  endfunction

  function void check_result(access_result_t got);
    access_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: result with no access outstanding", $realtime);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.l1_hit !== e.l1_hit) begin
      $display("%0t: l1_hit expected %0d actual %0d", $realtime, e.l1_hit, got.l1_hit);
      errors++;
    end
    if (got.victim_hit !== e.victim_hit) begin
      $display("%0t: victim_hit expected %0d actual %0d", $realtime, e.victim_hit,
               got.victim_hit);
      errors++;
    end
    if (got.demand_wb !== e.demand_wb) begin
      $display("%0t: demand_writeback expected %0d actual %0d", $realtime, e.demand_wb,
               got.demand_wb);
      errors++;
    end
    if (got.useful_pf !== e.useful_pf) begin
      $display("%0t: useful_prefetch expected %0d actual %0d", $realtime, e.useful_pf,
               got.useful_pf);
      errors++;
    end
    if (got.pf_count !== e.pf_count) begin
      $display("%0t: prefetch_count expected %0d actual %0d", $realtime, e.pf_count,
               got.pf_count);
      errors++;
    end
    if (got.pf_wbs !== e.pf_wbs) begin
      $display("%0t: prefetch_writebacks expected %0d actual %0d", $realtime, e.pf_wbs,
               got.pf_wbs);
      errors++;
    end
  endfunction
endclass

module tb;
  import cvsp_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic             operation_i = 1'b0;
  logic [AddrW-1:0] address_i = '0;
  logic             cfg_we_i = 1'b0;
  logic [2:0]       cfg_idx_i = '0;
  logic [4:0]       cfg_data_i = '0;
  logic             done_o;
  logic             l1_hit_o, victim_hit_o, demand_writeback_o, useful_prefetch_o;
  logic [3:0]       prefetch_count_o, prefetch_writebacks_o;

  cache_scoreboard sb;
  bit              idle_on;
  bit [63:0]       recent_q[$];

  cache_victim_stride_prefetch_top dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result('{l1_hit_o, victim_hit_o, demand_writeback_o, useful_prefetch_o,
                        prefetch_count_o, prefetch_writebacks_o});
  end

  task automatic idle_burst();
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 9)) @(negedge clk_i);
  endtask

  // busy cannot change between the falling and the rising edge
  task automatic issue_access(bit wr, bit [63:0] addr);
    idle_burst();
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    start_i = 1'b1;
    operation_i = wr;
    address_i = addr;
    sb.note_access(wr, addr);
    recent_q.push_back(addr);
    if (recent_q.size() > 24) void'(recent_q.pop_front());
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (busy_o || sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_geometry(bit [4:0] lines, bit [4:0] offs, bit [4:0] ways,
                              bit [4:0] vics, bit [4:0] deg);
    bit [4:0] vals[5];
    vals = '{lines, offs, ways, vics, deg};
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_we_i = 1'b1;
      cfg_idx_i = cfg_idx_e'(i);
      cfg_data_i = vals[i];
      sb.write_reg(cfg_idx_e'(i), vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
    recent_q.delete();
  endtask

  task automatic random_phase(int n_items);
    bit [63:0] base, stride, conflict_hi;
    int sent, run_len;
    int unsigned kind;
    sent = 0;
    conflict_hi = {$urandom, $urandom};
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // strided stream with random content
        base = ($urandom_range(0, 1)) ? {$urandom, $urandom} : 64'($urandom_range(0, 4095));
        stride = 64'(int'($urandom_range(0, 8)) - 4) << sb.boff;
        if ($urandom_range(0, 5) == 0) stride = {$urandom, $urandom};
        run_len = $urandom_range(3, 10);
        for (int j = 0; j < run_len; j++) begin
          issue_access(1'($urandom_range(0, 1)), base + stride * j);
          sent++;
        end
      end else if (kind < 7 && recent_q.size() != 0) begin
        issue_access(1'($urandom_range(0, 1)),
                     recent_q[$urandom_range(0, recent_q.size() - 1)]);
        sent++;
      end else if (kind < 9) begin
        // few tags on few sets to force evictions and victim traffic
        issue_access(1'($urandom_range(0, 1)),
                     (64'($urandom_range(0, 5)) << (sb.boff + sb.idx_bits)) ^
                     (64'($urandom_range(0, 3)) << sb.boff) ^
                     ($urandom_range(0, 1) ? conflict_hi : 64'd0));
        sent++;
      end else begin
        issue_access(1'($urandom_range(0, 1)), {$urandom, $urandom});
        sent++;
      end
    end
  endtask

  initial begin
    #8ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    sb = new();
    idle_on = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part under the reset geometry: 256 sets of 2 ways, 32-byte lines
    issue_access(1'b0, 64'h0);
    issue_access(1'b1, 64'h0);
    issue_access(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    issue_access(1'b1, 64'h2000);
    issue_access(1'b0, 64'h4000);              // evicts dirty line to victim buffer
    issue_access(1'b0, 64'h6000);
    issue_access(1'b1, 64'h8000);              // victim hit on a prefetched block
    issue_access(1'b0, 64'h6000);
    issue_access(1'b0, 64'h4000);              // miss; equal strides start prefetch
    issue_access(1'b0, 64'h10_0000);
    issue_access(1'b0, 64'h10_0040);
    issue_access(1'b0, 64'h10_0080);           // equal strides start prefetch
    issue_access(1'b0, 64'h10_00C0);
    issue_access(1'b1, 64'h10_0100);
    issue_access(1'b0, 64'hFFFF_FFFF_FFFF_FFC0);
    issue_access(1'b0, 64'hFFFF_FFFF_FFFF_FFE0);
    issue_access(1'b0, 64'h0000_0000_0000_0000); // stride wraps through zero
    issue_access(1'b0, 64'h0000_0000_0000_0020);
    issue_access(1'b1, 64'h8000_0000_0000_0000);

    set_geometry(5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
    random_phase(120);
    set_geometry(5'd10, 5'd16, 5'd4, 5'd8, 5'd8);
    random_phase(250);
    set_geometry(5'd15, 5'd31, 5'd7, 5'd15, 5'd15);
    random_phase(200);
    set_geometry(5'd3, 5'd4, 5'd1, 5'd2, 5'd3);
    random_phase(250);
    set_geometry(5'd4, 5'd0, 5'd4, 5'd8, 5'd1);
    random_phase(200);
    set_geometry(5'd6, 5'd6, 5'd2, 5'd0, 5'd8);
    random_phase(250);
    set_geometry(5'd2, 5'd3, 5'd3, 5'd1, 5'd0);
    random_phase(200);
    set_geometry(5'd9, 5'd5, 5'd1, 5'd2, 5'd2);
    idle_on = 1'b0;
    random_phase(300);

    drain();
    repeat (200) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
